/* rtl/hjc_pkg.sv */
package hjc_pkg;

   // Code points used by the composer.
   localparam logic [15:0] LEAD_FIRST   = 16'h1100;
   localparam logic [15:0] LEAD_LAST    = 16'h1112;
   localparam logic [15:0] VOWEL_FIRST  = 16'h1161;
   localparam logic [15:0] VOWEL_LAST   = 16'h1175;
   localparam logic [15:0] TAIL_BASE    = 16'h11a7;
   localparam logic [15:0] JAMO_LAST    = 16'h11c2;
   localparam logic [15:0] SYL_FIRST    = 16'hac00;
   localparam logic [15:0] SYL_LAST     = 16'hd7a3;
   localparam logic [15:0] VOWEL_STRIDE = 16'd588;
   localparam logic [15:0] TAIL_STRIDE  = 16'd28;
   localparam logic [15:0] ERASE_CODE   = 16'd8;

   // Most results one input item can cause.
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

   typedef struct packed {
      logic [15:0] code_in;
      logic        is_modifier;
      logic        clear_state;
   } req_type;

   typedef struct packed {
      logic [15:0] code_out;
      logic        erase;
      logic        last;
   } rsp_type;

   // All results of one item, handed from the step logic to the output stage.
   typedef struct packed {
      logic [IDX_W-1:0]                   count;
      logic [MAX_RESULTS-1:0][15:0]       code;
      logic [MAX_RESULTS-1:0]             erase;
   } grp_type;

   // A compound tail taken apart: the part kept and the consonant moved on.
   typedef struct packed {
      logic [15:0] keep;
      logic [15:0] moved;
   } split_type;

   // Lead consonant to the matching tail consonant, zero if there is none.
   function automatic logic [15:0] lead_to_tail(input logic [15:0] c);
      logic [15:0] r;
      case (c)
         16'h1100: r = 16'h11a8;
         16'h1101: r = 16'h11a9;
         16'h1102: r = 16'h11ab;
         16'h1103: r = 16'h11ae;
         16'h1105: r = 16'h11af;
         16'h1106: r = 16'h11b7;
         16'h1107: r = 16'h11b8;
         16'h1109: r = 16'h11ba;
         16'h110a: r = 16'h11bb;
         16'h110b: r = 16'h11bc;
         16'h110c: r = 16'h11bd;
         16'h110e: r = 16'h11be;
         16'h110f: r = 16'h11bf;
         16'h1110: r = 16'h11c0;
         16'h1111: r = 16'h11c1;
         16'h1112: r = 16'h11c2;
         default:  r = 16'h0000;
      endcase
      return r;
   endfunction

   // Tail consonant to the matching lead consonant, zero if there is none.
   function automatic logic [15:0] tail_to_lead(input logic [15:0] t);
      logic [15:0] r;
      case (t)
         16'h11a8: r = 16'h1100;
         16'h11a9: r = 16'h1101;
         16'h11ab: r = 16'h1102;
         16'h11ae: r = 16'h1103;
         16'h11af: r = 16'h1105;
         16'h11b7: r = 16'h1106;
         16'h11b8: r = 16'h1107;
         16'h11ba: r = 16'h1109;
         16'h11bb: r = 16'h110a;
         16'h11bc: r = 16'h110b;
         16'h11bd: r = 16'h110c;
         16'h11be: r = 16'h110e;
         16'h11bf: r = 16'h110f;
         16'h11c0: r = 16'h1110;
         16'h11c1: r = 16'h1111;
         16'h11c2: r = 16'h1112;
         default:  r = 16'h0000;
      endcase
      return r;
   endfunction

   // Compound tail formed by tail t and a following lead consonant c.
   function automatic logic [15:0] join_tail(input logic [15:0] t, input logic [15:0] c);
      logic [15:0] r;
      r = 16'h0000;
      case (t)
         16'h11a8: begin
            if (c == 16'h1100) r = 16'h11a9;
            else if (c == 16'h1109) r = 16'h11aa;
         end
         16'h11ab: begin
            if (c == 16'h110c) r = 16'h11ac;
            else if (c == 16'h1112) r = 16'h11ad;
         end
         16'h11af: begin
            case (c)
               16'h1100: r = 16'h11b0;
               16'h1106: r = 16'h11b1;
               16'h1107: r = 16'h11b2;
               16'h1109: r = 16'h11b3;
               16'h1110: r = 16'h11b4;
               16'h1111: r = 16'h11b5;
               16'h1112: r = 16'h11b6;
               default:  r = 16'h0000;
            endcase
         end
         16'h11b8: if (c == 16'h1109) r = 16'h11b9;
         16'h11ba: if (c == 16'h1109) r = 16'h11bb;
         default:  r = 16'h0000;
      endcase
      return r;
   endfunction

   // Compound vowel formed by vowel v and a following vowel c.
   function automatic logic [15:0] join_vowel(input logic [15:0] v, input logic [15:0] c);
      logic [15:0] r;
      r = 16'h0000;
      case (v)
         16'h1169: begin
            if (c == 16'h1161) r = 16'h116a;
            else if (c == 16'h1162) r = 16'h116b;
            else if (c == 16'h1175) r = 16'h116c;
         end
         16'h116e: begin
            if (c == 16'h1165) r = 16'h116f;
            else if (c == 16'h1166) r = 16'h1170;
            else if (c == 16'h1175) r = 16'h1171;
         end
         16'h1173: if (c == 16'h1175) r = 16'h1174;
         default:  r = 16'h0000;
      endcase
      return r;
   endfunction

   // Tail split when a vowel follows: compound tails leave their first half,
   // simple and double tails move whole.
   function automatic split_type split_tail(input logic [15:0] t);
      split_type s;
      s.keep  = 16'h0000;
      s.moved = 16'h0000;
      case (t)
         16'h11aa: begin s.keep = 16'h11a8; s.moved = 16'h1109; end
         16'h11ac: begin s.keep = 16'h11ab; s.moved = 16'h110c; end
         16'h11ad: begin s.keep = 16'h11ab; s.moved = 16'h1112; end
         16'h11b0: begin s.keep = 16'h11af; s.moved = 16'h1100; end
         16'h11b1: begin s.keep = 16'h11af; s.moved = 16'h1106; end
         16'h11b2: begin s.keep = 16'h11af; s.moved = 16'h1107; end
         16'h11b3: begin s.keep = 16'h11af; s.moved = 16'h1109; end
         16'h11b4: begin s.keep = 16'h11af; s.moved = 16'h1110; end
         16'h11b5: begin s.keep = 16'h11af; s.moved = 16'h1111; end
         16'h11b6: begin s.keep = 16'h11af; s.moved = 16'h1112; end
         16'h11b9: begin s.keep = 16'h11b8; s.moved = 16'h1109; end
         default:  s.moved = tail_to_lead(t);
      endcase
      return s;
   endfunction

   // Precomposed syllable code, modulo 2^16. An empty tail adds nothing.
   function automatic logic [15:0] syllable(input logic [15:0] l, input logic [15:0] v,
                                            input logic [15:0] t);
      logic [15:0] r;
      r = (l - LEAD_FIRST) * VOWEL_STRIDE + (v - VOWEL_FIRST) * TAIL_STRIDE + SYL_FIRST;
      if (t != 16'h0000) r = r + (t - TAIL_BASE);
      return r;
   endfunction

endpackage

/* rtl/hjc_step.sv */
module hjc_step
   import hjc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    grp_valid,
   input  logic    grp_ready,
   output grp_type grp_data
);

   logic        enable_ff;
   logic        item_valid_ff;
   logic        item_valid_in;
   req_type     item_ff;
   logic [15:0] lead_ff, vowel_ff, tail_ff;
   logic [15:0] lead_in, vowel_in, tail_in;
   logic        advance;
   logic [15:0] c;
   logic [15:0] new_tail;
   logic [15:0] new_vowel;
   logic [15:0] new_lead;
   split_type   split;
   logic        foreign;

   // The item leaves the input register once its results have a place in the
   // output stage; a clear item needs no place.
   assign advance   = item_valid_ff && (item_ff.clear_state || grp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign grp_valid = item_valid_ff && !item_ff.clear_state;
   assign item_valid_in = (req_valid && req_ready) || (item_valid_ff && !advance);

   // Composition enable register.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         enable_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   // Syllable state, updated as the item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= '0;
         vowel_ff <= '0;
         tail_ff  <= '0;
      end else if (advance) begin
         lead_ff  <= lead_in;
         vowel_ff <= vowel_in;
         tail_ff  <= tail_in;
      end
   end

   assign c       = item_ff.code_in;
   assign foreign = (c != 16'h0000) && ((c < LEAD_FIRST) || (c > JAMO_LAST)) &&
                    ((c < SYL_FIRST) || (c > SYL_LAST));
   assign split   = split_tail(tail_ff);
   assign new_lead  = (split.moved != 16'h0000) ? split.moved : lead_ff;
   assign new_vowel = join_vowel(vowel_ff, c);

   // Tail candidate for a lead consonant key.
   always_comb begin
      new_tail = 16'h0000;
      if (lead_ff != 16'h0000 && vowel_ff != 16'h0000) begin
         new_tail = (tail_ff == 16'h0000) ? lead_to_tail(c) : join_tail(tail_ff, c);
      end
   end

   // Composition step: next state and the results of this item.
   always_comb begin
      lead_in  = lead_ff;
      vowel_in = vowel_ff;
      tail_in  = tail_ff;
      grp_data.count = IDX_W'(1);
      grp_data.code  = '0;
      grp_data.erase = '0;
      grp_data.code[0] = c;

      if (item_ff.clear_state) begin
         lead_in  = '0;
         vowel_in = '0;
         tail_in  = '0;
      end else if (!enable_ff) begin
         // Pass through, state untouched.
      end else if (foreign || (c == 16'h0000 && !item_ff.is_modifier)) begin
         lead_in  = '0;
         vowel_in = '0;
         tail_in  = '0;
      end else if (c >= LEAD_FIRST && c <= LEAD_LAST) begin
         if (new_tail == 16'h0000) begin
            // The consonant starts a new syllable.
            lead_in  = c;
            vowel_in = '0;
            tail_in  = '0;
         end else begin
            tail_in = new_tail;
            grp_data.count    = IDX_W'(2);
            grp_data.code[0]  = ERASE_CODE;
            grp_data.erase[0] = 1'b1;
            grp_data.code[1]  = syllable(lead_ff, vowel_ff, new_tail);
         end
      end else if (c >= VOWEL_FIRST && c <= VOWEL_LAST) begin
         if (lead_ff == 16'h0000) begin
            lead_in  = '0;
            vowel_in = '0;
            tail_in  = '0;
         end else if (vowel_ff == 16'h0000) begin
            vowel_in = c;
            grp_data.count    = IDX_W'(2);
            grp_data.code[0]  = ERASE_CODE;
            grp_data.erase[0] = 1'b1;
            grp_data.code[1]  = syllable(lead_ff, c, tail_ff);
         end else if (tail_ff == 16'h0000) begin
            if (new_vowel == 16'h0000) begin
               lead_in  = '0;
               vowel_in = '0;
               tail_in  = '0;
            end else begin
               vowel_in = new_vowel;
               grp_data.count    = IDX_W'(2);
               grp_data.code[0]  = ERASE_CODE;
               grp_data.erase[0] = 1'b1;
               grp_data.code[1]  = syllable(lead_ff, new_vowel, 16'h0000);
            end
         end else begin
            // The tail, or its second half, moves to the lead of a new syllable.
            lead_in  = new_lead;
            vowel_in = c;
            tail_in  = '0;
            grp_data.count    = IDX_W'(3);
            grp_data.code[0]  = ERASE_CODE;
            grp_data.erase[0] = 1'b1;
            grp_data.code[1]  = (split.moved != 16'h0000) ?
                                syllable(lead_ff, vowel_ff, split.keep) : 16'h0000;
            grp_data.code[2]  = syllable(new_lead, c, 16'h0000);
         end
      end
   end

endmodule

/* rtl/hjc_out.sv */
module hjc_out
   import hjc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    grp_valid,
   output logic    grp_ready,
   input  grp_type grp_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   grp_type          grp_ff;
   logic             valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             is_last;
   logic             load;

   // Results of the held group go out one transfer per cycle while rsp_ready is high.
   assign is_last   = (idx_ff == grp_ff.count - IDX_W'(1));
   assign rsp_valid = valid_ff;
   assign rsp_data.code_out = grp_ff.code[idx_ff];
   assign rsp_data.erase    = grp_ff.erase[idx_ff];
   assign rsp_data.last     = is_last;

   // A new group enters as the last result of the old one is taken.
   assign grp_ready = !valid_ff || (rsp_ready && is_last);
   assign load      = grp_valid && grp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && rsp_ready) begin
         if (is_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_data;
      end
   end

endmodule

/* rtl/hangul_jamo_composer.sv */
// Two-set Hangul composer: each accepted key code updates the lead, vowel and
// tail of the syllable being built, while composition is enabled, and yields
// one to three results (an erase, a finished syllable, the new code), the
// final one flagged by last; a clear item yields none. An item waits in the
// input register until its results have a place in the result register;
// they then leave it one per cycle while rsp_ready is high, and a new item is
// accepted while results of the previous one are still being taken.
module hangul_jamo_composer
   import hjc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    grp_valid;
   logic    grp_ready;
   grp_type grp_data;

   // Input register, syllable state and composition logic.
   hjc_step u_step (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .grp_valid   (grp_valid),
      .grp_ready   (grp_ready),
      .grp_data    (grp_data)
   );

   // Result register and serializer.
   hjc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (grp_valid),
      .grp_ready (grp_ready),
      .grp_data  (grp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
